@@ rtl/core/pra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pra_pkg;

  localparam int TABLE_ENTRIES    = 64;
  localparam int PAGE_NUMBER_BITS = 20;
  localparam int IDX_BITS         = $clog2(TABLE_ENTRIES);
  localparam int CNT_BITS         = PAGE_NUMBER_BITS + 1;
  localparam int ENTRY_BITS       = PAGE_NUMBER_BITS + CNT_BITS;
  localparam int CFG_IDX_BITS     = 1;

  localparam logic [CNT_BITS-1:0]         PAGE_SPAN   = {1'b1, {PAGE_NUMBER_BITS{1'b0}}};
  localparam logic [PAGE_NUMBER_BITS-1:0] RESET_BASE  = PAGE_NUMBER_BITS'(4);
  localparam logic [CNT_BITS-1:0]         RESET_COUNT = CNT_BITS'(1024);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_INIT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOFIT    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ARENA_BASE  = 1'd0,
    REG_ARENA_COUNT = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_pass2;
    logic scan_run;
    logic commit;
    logic write2;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic need_pass2;
    logic need_write2;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/pra_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pra_ctrl
  import pra_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic [1:0] in_cmd,
  input  wire dp_stat_t stat_i,
  output ctl_cmd_t      cmd_o,
  output logic          busy
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SCAN2  = 5'b00100,
    S_COMMIT = 5'b01000,
    S_WRITE2 = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (op_t'(in_cmd) == OP_INIT) begin
            state_nxt = S_COMMIT;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_nxt        = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          if (stat_i.need_pass2) begin
            cmd_o.scan_start = 1'b1;
            cmd_o.scan_pass2 = 1'b1;
            state_nxt        = S_SCAN2;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_SCAN2: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_nxt    = stat_i.need_write2 ? S_WRITE2 : S_IDLE;
      end
      S_WRITE2: begin
        cmd_o.write2 = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.commit |=> !cmd_o.commit)
    else $error("two commits in a row");

  a_write2_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.write2 |-> $past(cmd_o.commit))
    else $error("second write without a commit before it");

endmodule
`default_nettype wire

@@ rtl/core/pra_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pra_datapath
  import pra_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ctl_cmd_t                    cmd_i,
  output dp_stat_t                         stat_o,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [CNT_BITS-1:0]         in_page_count,
  input  wire logic [PAGE_NUMBER_BITS-1:0] in_page_addr,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [CNT_BITS-1:0]         cfg_data,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [PAGE_NUMBER_BITS-1:0]      out_base_page,
  output logic [CNT_BITS-1:0]              out_range_pages
);

  localparam int PB = PAGE_NUMBER_BITS;

  logic [PB-1:0]       arena_base_r;
  logic [CNT_BITS-1:0] arena_count_r;

  op_t                 op_r;
  logic [CNT_BITS-1:0] req_r;
  logic [PB-1:0]       addr_r;

  logic [TABLE_ENTRIES-1:0] valid_r, free_r;
  logic                     boot_r;
  logic [ENTRY_BITS-1:0]    mem_r [TABLE_ENTRIES];
  logic [ENTRY_BITS-1:0]    rd_data_r;

  logic [IDX_BITS:0]   idx_r;
  logic                pass2_r;
  logic                rd_vld_r, rd_valid_r, rd_free_r, rd_boot_r;
  logic [IDX_BITS-1:0] rd_idx_r;
  logic                issue;

  logic                fit_found_r, spare_found_r, hit_found_r, left_found_r, right_found_r;
  logic [IDX_BITS-1:0] fit_idx_r, spare_idx_r, hit_idx_r, left_idx_r, right_idx_r;
  logic [PB-1:0]       fit_base_r, hit_base_r, left_base_r;
  logic [CNT_BITS-1:0] fit_pages_r, hit_pages_r, left_pages_r, right_pages_r;

  logic [PB-1:0]       e_base;
  logic [CNT_BITS-1:0] e_pages;
  logic                a_fit, a_spare, f_hit, f_left, f_right, q_hit;
  logic [PB+1:0]       e_end;
  logic [PB+1:0]       hit_end;
  logic [PB-1:0]       q_off;

  logic                wr_en;
  logic [IDX_BITS-1:0] wr_addr;
  logic [ENTRY_BITS-1:0] wr_data;

  logic [CNT_BITS-1:0] span_left, init_cnt;
  logic                exact, split_ok;
  status_t             st;
  logic [PB-1:0]       res_base;
  logic [CNT_BITS-1:0] res_pages;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_base_r  <= RESET_BASE;
      arena_count_r <= RESET_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ARENA_BASE:  arena_base_r  <= cfg_data[PB-1:0];
        REG_ARENA_COUNT: arena_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r   <= op_t'(in_cmd);
      req_r  <= in_page_count;
      addr_r <= in_page_addr;
    end
  end

  // Scan sequencing: one table read per cycle, evaluated in the cycle after the read.
  assign issue = cmd_i.scan_run && !cmd_i.scan_start && !idx_r[IDX_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      pass2_r  <= 1'b0;
      rd_vld_r <= 1'b0;
    end else if (cmd_i.scan_start) begin
      idx_r    <= '0;
      pass2_r  <= cmd_i.scan_pass2;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (issue) begin
        idx_r <= idx_r + (IDX_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx_r   <= idx_r[IDX_BITS-1:0];
      rd_valid_r <= valid_r[idx_r[IDX_BITS-1:0]];
      rd_free_r  <= free_r[idx_r[IDX_BITS-1:0]];
      rd_boot_r  <= boot_r && (idx_r[IDX_BITS-1:0] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem_r[idx_r[IDX_BITS-1:0]];
    end
  end

  // Entry zero keeps its reset contents until it is first written.
  assign e_base  = rd_boot_r ? RESET_BASE  : rd_data_r[ENTRY_BITS-1:CNT_BITS];
  assign e_pages = rd_boot_r ? RESET_COUNT : rd_data_r[CNT_BITS-1:0];
  assign e_end   = {2'b00, e_base} + {1'b0, e_pages};
  assign hit_end = {2'b00, addr_r} + {1'b0, hit_pages_r};
  assign q_off   = addr_r - e_base;

  always_comb begin
    a_fit   = rd_valid_r && rd_free_r && (e_pages >= req_r)
              && (!fit_found_r || (e_base < fit_base_r));
    a_spare = !rd_valid_r && !spare_found_r;
    f_hit   = rd_valid_r && !rd_free_r && (e_base == addr_r);
    f_left  = rd_valid_r && rd_free_r && (e_end == {2'b00, addr_r});
    f_right = rd_valid_r && rd_free_r && ({2'b00, e_base} == hit_end);
    q_hit   = rd_valid_r && !rd_free_r && !hit_found_r && (addr_r >= e_base)
              && ({1'b0, q_off} < e_pages);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_found_r   <= 1'b0;
      spare_found_r <= 1'b0;
      hit_found_r   <= 1'b0;
      left_found_r  <= 1'b0;
      right_found_r <= 1'b0;
    end else if (cmd_i.scan_start) begin
      if (!cmd_i.scan_pass2) begin
        fit_found_r   <= 1'b0;
        spare_found_r <= 1'b0;
        hit_found_r   <= 1'b0;
        left_found_r  <= 1'b0;
      end
      right_found_r <= 1'b0;
    end else if (rd_vld_r) begin
      unique case (op_r)
        OP_ALLOC: begin
          if (a_fit) begin
            fit_found_r <= 1'b1;
          end
          if (a_spare) begin
            spare_found_r <= 1'b1;
          end
        end
        OP_FREE: begin
          if (!pass2_r) begin
            if (f_hit) begin
              hit_found_r <= 1'b1;
            end
            if (f_left) begin
              left_found_r <= 1'b1;
            end
          end else if (f_right) begin
            right_found_r <= 1'b1;
          end
        end
        OP_QUERY: begin
          if (q_hit) begin
            hit_found_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && !cmd_i.scan_start) begin
      unique case (op_r)
        OP_ALLOC: begin
          if (a_fit) begin
            fit_idx_r   <= rd_idx_r;
            fit_base_r  <= e_base;
            fit_pages_r <= e_pages;
          end
          if (a_spare) begin
            spare_idx_r <= rd_idx_r;
          end
        end
        OP_FREE: begin
          if (!pass2_r) begin
            if (f_hit) begin
              hit_idx_r   <= rd_idx_r;
              hit_pages_r <= e_pages;
            end
            if (f_left) begin
              left_idx_r   <= rd_idx_r;
              left_base_r  <= e_base;
              left_pages_r <= e_pages;
            end
          end else if (f_right) begin
            right_idx_r   <= rd_idx_r;
            right_pages_r <= e_pages;
          end
        end
        OP_QUERY: begin
          if (q_hit) begin
            hit_base_r  <= e_base;
            hit_pages_r <= e_pages;
          end
        end
        default: ;
      endcase
    end
  end

  // Result and table update of the finished request.
  assign span_left = PAGE_SPAN - {1'b0, arena_base_r};
  assign init_cnt  = (arena_count_r > span_left) ? span_left : arena_count_r;
  assign exact     = (fit_pages_r == req_r);
  assign split_ok  = (req_r != '0) && fit_found_r && !exact && spare_found_r;

  always_comb begin
    st        = ST_OK;
    res_base  = '0;
    res_pages = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    unique case (op_r)
      OP_ALLOC: begin
        priority if (req_r == '0) begin
          st = ST_ZERO;
        end else if (!fit_found_r) begin
          st = ST_NOFIT;
        end else if (!exact && !spare_found_r) begin
          st = ST_FULL;
        end else begin
          res_base  = fit_base_r;
          res_pages = req_r;
          wr_en     = cmd_i.commit && !exact;
          wr_addr   = spare_idx_r;
          wr_data   = {fit_base_r, req_r};
        end
      end
      OP_FREE: begin
        if (!hit_found_r) begin
          st = ST_NOTFOUND;
        end else begin
          res_base  = addr_r;
          res_pages = hit_pages_r;
          wr_en     = cmd_i.commit;
          wr_addr   = hit_idx_r;
          wr_data   = {(left_found_r ? left_base_r : addr_r),
                       CNT_BITS'(hit_pages_r
                                 + (left_found_r ? left_pages_r : '0)
                                 + (right_found_r ? right_pages_r : '0))};
        end
      end
      OP_QUERY: begin
        if (!hit_found_r) begin
          st = ST_NOTFOUND;
        end else begin
          res_base  = hit_base_r;
          res_pages = hit_pages_r;
        end
      end
      OP_INIT: begin
        res_base  = arena_base_r;
        res_pages = init_cnt;
        wr_en     = cmd_i.commit;
        wr_addr   = '0;
        wr_data   = {arena_base_r, init_cnt};
      end
      default: ;
    endcase
    if (cmd_i.write2) begin
      wr_en   = 1'b1;
      wr_addr = fit_idx_r;
      wr_data = {PB'(fit_base_r + req_r[PB-1:0]), CNT_BITS'(fit_pages_r - req_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= TABLE_ENTRIES'(1);
      free_r  <= TABLE_ENTRIES'(1);
      boot_r  <= 1'b1;
    end else begin
      if (wr_en && (wr_addr == '0)) begin
        boot_r <= 1'b0;
      end
      if (cmd_i.commit) begin
        unique case (op_r)
          OP_ALLOC: begin
            if ((req_r != '0) && fit_found_r) begin
              if (exact) begin
                free_r[fit_idx_r] <= 1'b0;
              end else if (spare_found_r) begin
                valid_r[spare_idx_r] <= 1'b1;
                free_r[spare_idx_r]  <= 1'b0;
              end
            end
          end
          OP_FREE: begin
            if (hit_found_r) begin
              free_r[hit_idx_r] <= 1'b1;
              if (left_found_r) begin
                valid_r[left_idx_r] <= 1'b0;
                free_r[left_idx_r]  <= 1'b0;
              end
              if (right_found_r) begin
                valid_r[right_idx_r] <= 1'b0;
                free_r[right_idx_r]  <= 1'b0;
              end
            end
          end
          OP_INIT: begin
            valid_r <= (init_cnt != '0) ? TABLE_ENTRIES'(1) : '0;
            free_r  <= (init_cnt != '0) ? TABLE_ENTRIES'(1) : '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd_i.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      out_status      <= st;
      out_base_page   <= res_base;
      out_range_pages <= res_pages;
    end
  end

  assign stat_o.scan_done   = idx_r[IDX_BITS] && !rd_vld_r;
  assign stat_o.need_pass2  = (op_r == OP_FREE) && hit_found_r && !pass2_r;
  assign stat_o.need_write2 = (op_r == OP_ALLOC) && split_ok;

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> !idx_r[IDX_BITS])
    else $error("table read past the last entry");

  a_split_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.write2 |-> (spare_found_r && fit_found_r && (spare_idx_r != fit_idx_r)))
    else $error("split without a spare entry");

  a_result_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd_i.commit))
    else $error("result strobe without a commit");

endmodule
`default_nettype wire

@@ rtl/core/page_range_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                Payload
// in_       start, busy              in_cmd, in_page_count, in_page_addr
// out_      out_valid (1-cycle)      out_status, out_base_page, out_range_pages
// cfg_      cfg_valid, cfg_ready     cfg_index, cfg_data
//
// Alloc and query make one sweep of the range table and free makes one or two (a
// second table sweep looks for the upper neighbor). A sweep reads the range table
// through its single read port, one entry per cycle; then come a commit cycle and
// the result strobe. A split alloc stays busy longer for its second table write.
// Init makes no sweep and goes straight to the commit.
// The result strobe comes in the cycle after the commit that updates the table; a split's second write falls in it.
// Reset is synchronous and leaves a single free range of 1024 pages at page 4.
// The receiver cannot stall; configuration writes are always taken.
module page_range_allocator_unit
  import pra_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [CNT_BITS-1:0]         in_page_count,
  input  wire logic [PAGE_NUMBER_BITS-1:0] in_page_addr,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [PAGE_NUMBER_BITS-1:0]      out_base_page,
  output logic [CNT_BITS-1:0]              out_range_pages,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [CNT_BITS-1:0]         cfg_data
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  pra_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat_i (dp_stat),
    .cmd_o  (ctl_cmd),
    .busy   (busy)
  );

  pra_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (ctl_cmd),
    .stat_o          (dp_stat),
    .in_cmd          (in_cmd),
    .in_page_count   (in_page_count),
    .in_page_addr    (in_page_addr),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_base_page   (out_base_page),
    .out_range_pages (out_range_pages)
  );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import pra_pkg::*;

  localparam int NE = TABLE_ENTRIES;
  localparam int PB = PAGE_NUMBER_BITS;
  localparam int CB = CNT_BITS;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_cmd = '0;
  logic [CB-1:0] in_page_count = '0;
  logic [PB-1:0] in_page_addr = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [PB-1:0] out_base_page;
  logic [CB-1:0] out_range_pages;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CB-1:0] cfg_data = '0;

  page_range_allocator_unit i_dut (.*);

  initial forever #5 clk = ~clk;

  typedef struct packed {
    logic [2:0] status;
    logic [PB-1:0] base;
    logic [CB-1:0] pages;
  } grant_t;

  grant_t expected_grants[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;
  bit timed_out = 0;

  // Shadow copy of the range table and arena registers.
  logic [PB-1:0] arena_base = RESET_BASE;
  logic [CB-1:0] arena_count = RESET_COUNT;
  bit tv[NE];
  bit tf[NE];
  logic [PB:0] tb_base[NE];
  logic [CB:0] tp[NE];

  function automatic logic [CB-1:0] load_table();
    logic [CB:0] cnt;
    cnt = arena_count;
    if (cnt > (PAGE_SPAN - arena_base)) cnt = PAGE_SPAN - arena_base;
    for (int i = 0; i < NE; i++) begin
      tv[i] = 0; tf[i] = 0; tb_base[i] = 0; tp[i] = 0;
    end
    if (cnt != 0) begin
      tv[0] = 1; tf[0] = 1; tb_base[0] = arena_base; tp[0] = cnt;
    end
    return cnt[CB-1:0];
  endfunction

  function automatic grant_t predict_grant(logic [1:0] op, logic [CB-1:0] req,
                                           logic [PB-1:0] addr);
    int fit, spare, hit;
    logic [PB:0] b;
    logic [CB:0] p;
    grant_t g;
    fit = -1; spare = -1; hit = -1;
    g = '{ST_NOTFOUND, '0, '0};
    case (op)
      OP_INIT: begin
        g.pages = load_table();
        g = '{ST_OK, arena_base, g.pages};
      end
      OP_ALLOC: begin
        if (req == 0) return '{ST_ZERO, '0, '0};
        for (int i = 0; i < NE; i++) begin
          if (!tv[i]) begin
            if (spare < 0) spare = i;
          end else if (tf[i] && tp[i] >= req &&
                       (fit < 0 || tb_base[i] < tb_base[fit])) begin
            fit = i;
          end
        end
        if (fit < 0) return '{ST_NOFIT, '0, '0};
        if (tp[fit] == req) begin
          tf[fit] = 0;
          return '{ST_OK, tb_base[fit][PB-1:0], req};
        end
        if (spare < 0) return '{ST_FULL, '0, '0};
        tv[spare] = 1; tf[spare] = 0; tb_base[spare] = tb_base[fit]; tp[spare] = req;
        tb_base[fit] += req; tp[fit] -= req;
        g = '{ST_OK, tb_base[spare][PB-1:0], req};
      end
      OP_FREE: begin
        for (int i = 0; i < NE; i++)
          if (tv[i] && !tf[i] && tb_base[i] == addr) hit = i;
        if (hit < 0) return '{ST_NOTFOUND, '0, '0};
        b = tb_base[hit]; p = tp[hit];
        tf[hit] = 1;
        for (int i = 0; i < NE; i++) begin
          if (i == hit || !tv[i] || !tf[i]) continue;
          if (tb_base[i] + tp[i] == b) begin
            tb_base[hit] = tb_base[i]; tp[hit] += tp[i];
            tv[i] = 0; tf[i] = 0; tb_base[i] = 0; tp[i] = 0;
          end else if (tb_base[i] == b + p) begin
            tp[hit] += tp[i];
            tv[i] = 0; tf[i] = 0; tb_base[i] = 0; tp[i] = 0;
          end
        end
        g = '{ST_OK, b[PB-1:0], p[CB-1:0]};
      end
      default: begin
        for (int i = 0; i < NE; i++)
          if (tv[i] && !tf[i] && addr >= tb_base[i] && addr - tb_base[i] < tp[i])
            return '{ST_OK, tb_base[i][PB-1:0], tp[i][CB-1:0]};
      end
    endcase
    return g;
  endfunction

  // Result checker and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT && !timed_out) begin
        timed_out = 1;
        $display("TB_ERROR");
        $finish;
      end
    end
    if (rst_n && out_valid) begin
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", out_status);
      end else begin
        grant_t e;
        e = expected_grants.pop_front();
        if (e.status !== out_status || e.base !== out_base_page ||
            e.pages !== out_range_pages) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d base=%0d pages=%0d got st=%0d base=%0d pages=%0d",
                     e.status, e.base, e.pages, out_status, out_base_page,
                     out_range_pages);
        end
      end
    end
  end

  task automatic send_request(logic [1:0] op, logic [CB-1:0] req, logic [PB-1:0] addr);
    while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    start <= 1'b1;
    in_cmd <= op;
    in_page_count <= req;
    in_page_addr <= addr;
    do @(posedge clk); while (busy);
    expected_grants.push_back(predict_grant(op, req, addr));
    start <= 1'b0;
    // The block is busy on the next edge anyway, so this costs no throughput.
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CB-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ARENA_BASE) arena_base = val[PB-1:0];
    else arena_count = val;
    @(posedge clk);
  endtask

  task automatic set_arena(logic [CB-1:0] base, logic [CB-1:0] cnt);
    drain();
    write_reg(REG_ARENA_BASE, base);
    write_reg(REG_ARENA_COUNT, cnt);
    send_request(OP_INIT, CB'($urandom), PB'($urandom));
  endtask

  // Picks an address that is likely to hit a used range base or interior.
  function automatic logic [PB-1:0] pick_addr(bit interior);
    int i;
    i = $urandom_range(NE - 1);
    if (tv[i] && $urandom_range(9) < 8) begin
      if (interior && tp[i] > 1)
        return PB'(tb_base[i] + $urandom_range(tp[i] - 1));
      return tb_base[i][PB-1:0];
    end
    return PB'($urandom);
  endfunction

  task automatic test_directed();
    send_request(OP_QUERY, 0, RESET_BASE);
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_ALLOC, 4, 0);
    send_request(OP_QUERY, 0, 7);
    send_request(OP_ALLOC, 1024, 0);
    send_request(OP_ALLOC, 1020, '1);
    send_request(OP_FREE, '1, 5);
    send_request(OP_FREE, 0, 4);
    send_request(OP_FREE, 0, 4);
    send_request(OP_QUERY, 0, 4);
    send_request(OP_ALLOC, {CB{1'b1}}, 0);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_ALLOC, 2, 0);
    send_request(OP_FREE, 0, 4);
    send_request(OP_FREE, 0, 5);
    // Fill the table with single-page splits until it runs out of entries.
    for (int k = 0; k < NE + 1; k++) send_request(OP_ALLOC, 1, 0);
    // Arena clipped at the top of the page space, then one spanning the whole page space, then an empty one.
    set_arena({1'b0, {PB{1'b1}}}, {CB{1'b1}});
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_QUERY, 0, {PB{1'b1}});
    set_arena(0, PAGE_SPAN);
    send_request(OP_ALLOC, PAGE_SPAN, 0);
    send_request(OP_QUERY, 0, {PB{1'b1}});
    set_arena(12345, 0);
    send_request(OP_ALLOC, 1, 0);
  endtask

  task automatic test_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        if ($urandom_range(19) == 0) send_request(OP_ALLOC, CB'($urandom), PB'($urandom));
        else send_request(OP_ALLOC, CB'($urandom_range(1, 40)), PB'($urandom));
      end else if (r < 75) send_request(OP_FREE, CB'($urandom), pick_addr(0));
      else if (r < 95) send_request(OP_QUERY, CB'($urandom), pick_addr(1));
      else send_request(OP_INIT, CB'($urandom), PB'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    void'(load_table());
    @(posedge clk);
    send_gap_pct = 29;
    test_directed();
    set_arena(RESET_BASE, 600);
    test_random(330);
    send_gap_pct = 55;
    set_arena(CB'($urandom), CB'($urandom_range(1, 3000)));
    test_random(330);
    drain();
    send_gap_pct = 0;
    set_arena(CB'({1'b0, {PB{1'b1}}} - 500), {CB{1'b1}});
    test_random(330);
    drain();
    repeat (140) @(posedge clk);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
